FILE: hw/rtl/pafk_pkg.sv
// Shared types, constants and helpers for the planar arm forward kinematics block.
// No dependencies; every other file imports this package.
package pafk_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int LINK_COUNT   = 3;
	localparam int NLINK        = (LINK_COUNT > 3) ? 3 : LINK_COUNT;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int QDEPTH       = 4;
	localparam int QAW          = 2;
	localparam int CW           = 34;
	localparam int JW           = 38;

	localparam logic [2:0] REG_LEN_ONE   = 3'd0;
	localparam logic [2:0] REG_LEN_TWO   = 3'd1;
	localparam logic [2:0] REG_LEN_THREE = 3'd2;
	localparam logic [2:0] REG_HEIGHT    = 3'd3;

	typedef struct packed {
		logic [31:0]        bx;
		logic [31:0]        by;
		logic signed [17:0] s1;
		logic signed [17:0] s2;
		logic signed [17:0] s3;
	} job_t;

	typedef struct packed {
		logic        vld;
		logic [1:0]  idx;
		logic        last;
		logic [31:0] len;
		logic [31:0] bx;
		logic [31:0] by;
	} tag_t;

	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + 36'sd16384) >>> 15;
		if (r > 36'sd32767)
			return 16'sh7FFF;
		else if (r < -36'sd32768)
			return 16'sh8000;
		return r[15:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [JW-1:0] v);
		if (v > JW'(64'sd2147483647))
			return 32'h7FFFFFFF;
		else if (v < -JW'(64'sd2147483648))
			return 32'h80000000;
		return v[31:0];
	endfunction

endpackage

FILE: hw/rtl/pafk_fifo.sv
// Short job queue between the front and the back of the kinematics block.
// Depends on pafk_pkg for the job type and depth.
module pafk_fifo import pafk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic nonempty
);

	job_t         mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full     = (cnt_q == (QAW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/pafk_front.sv
// Input side: takes items, forms the cumulative joint angles, pushes jobs.
// Depends on pafk_pkg and feeds pafk_fifo.
module pafk_front import pafk_pkg::*; (
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // base_x, base_y, joint_angle_one/two/three
	input  logic         q_full,
	output logic         push,
	output job_t         job
);

	logic signed [15:0] ja1, ja2, ja3;

	assign ja1 = s_axis_tdata[79:64];
	assign ja2 = s_axis_tdata[95:80];
	assign ja3 = s_axis_tdata[111:96];

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		job.bx = s_axis_tdata[31:0];
		job.by = s_axis_tdata[63:32];
		job.s1 = 18'(ja1);
		job.s2 = job.s1 + 18'(ja2);
		job.s3 = job.s2 + 18'(ja3);
	end

endmodule

FILE: hw/rtl/pafk_cordic.sv
// Pipelined rotation CORDIC: phase (2^32 per turn) to Q1.15 cosine and sine.
// Depends on pafk_pkg for the arctangent table and rounding helper.
module pafk_cordic import pafk_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [15:0] cos_q,
	output logic signed [15:0] sin_q
);

	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] z_s [CORDIC_STEPS+1];
	logic [1:0]           q_s [CORDIC_STEPS+1];
	logic [31:0]          psum, ru;
	logic [1:0]           quad;
	logic signed [35:0]   xe, ye, xr, yr;

	assign psum = phase + 32'h20000000;
	assign quad = psum[31:30];
	assign ru   = phase - {quad, 30'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CW'(652032874);
			y_s[0] <= '0;
			z_s[0] <= CW'($signed(ru));
			q_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CW-1:0] at;
		assign at = $signed({{(CW-32){1'b0}}, atan_at(5'(i))});
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	assign xe = 36'(x_s[CORDIC_STEPS]);
	assign ye = 36'(y_s[CORDIC_STEPS]);

	always_comb begin
		unique case (q_s[CORDIC_STEPS])
			2'd1: begin xr = -ye; yr = xe;  end
			2'd2: begin xr = -xe; yr = -ye; end
			2'd3: begin xr = ye;  yr = -xe; end
			default: begin xr = xe; yr = ye; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= to_q15(xr);
			sin_q <= to_q15(yr);
		end
	end

endmodule

FILE: hw/rtl/pafk_back.sv
// Back end: issues base and link slots, runs trig, scales offsets, walks joints.
// Depends on pafk_pkg and two pafk_cordic instances.
module pafk_back import pafk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  job_t         job,
	input  logic         job_vld,
	output logic         job_pop,
	input  logic [31:0]  len_one,
	input  logic [31:0]  len_two,
	input  logic [31:0]  len_three,
	input  logic [31:0]  height,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // pose_x, pose_y, pose_z, quat_z, quat_w
	output logic         m_axis_tlast,  // last_pose
	output logic [1:0]   m_axis_tuser   // body_index
);

	logic                en;
	logic [1:0]          cnt_q;
	logic signed [17:0]  sum_sel;
	logic [31:0]         len_sel;
	tag_t                tag_in;
	tag_t                tag_s [CORDIC_LAT];
	logic signed [15:0]  c_full, s_full, c_half, s_half;

	tag_t                tag_s1, tag_s2;
	logic signed [48:0]  px_s1, py_s1;
	logic signed [15:0]  hc_s1, hs_s1, hc_s2, hs_s2;
	logic signed [32:0]  ox_s2, oy_s2;
	logic signed [48:0]  rx, ry;
	logic signed [JW-1:0] jx_q, jy_q, cx, cy;

	logic        out_vld_q, out_last_q;
	logic [1:0]  out_idx_q;
	logic [31:0] out_x_q, out_y_q, out_z_q;
	logic [15:0] out_qz_q, out_qw_q;

	assign en      = !out_vld_q || m_axis_tready;
	assign job_pop = job_vld && en && (cnt_q == 2'(NLINK));

	always_comb begin
		unique case (cnt_q)
			2'd1:    begin sum_sel = job.s1; len_sel = len_one;   end
			2'd2:    begin sum_sel = job.s2; len_sel = len_two;   end
			2'd3:    begin sum_sel = job.s3; len_sel = len_three; end
			default: begin sum_sel = '0;     len_sel = '0;        end
		endcase
		tag_in.vld  = job_vld;
		tag_in.idx  = cnt_q;
		tag_in.last = (cnt_q == 2'(NLINK));
		tag_in.len  = len_sel;
		tag_in.bx   = job.bx;
		tag_in.by   = job.by;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en && job_vld) begin
			cnt_q <= tag_in.last ? 2'd0 : cnt_q + 2'd1;
		end
	end

	pafk_cordic u_full (
		.clk   (clk),
		.en    (en),
		.phase ({sum_sel[15:0], 16'b0}),
		.cos_q (c_full),
		.sin_q (s_full)
	);

	pafk_cordic u_half (
		.clk   (clk),
		.en    (en),
		.phase ({sum_sel[16:0], 15'b0}),
		.cos_q (c_half),
		.sin_q (s_half)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_LAT; i++)
				tag_s[i] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_in;
			for (int i = 1; i < CORDIC_LAT; i++)
				tag_s[i] <= tag_s[i-1];
		end
	end

	assign rx = px_s1 + 49'sd32768;
	assign ry = py_s1 + 49'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_s[CORDIC_LAT-1];
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({1'b0, tag_s[CORDIC_LAT-1].len}) * c_full;
			py_s1 <= $signed({1'b0, tag_s[CORDIC_LAT-1].len}) * s_full;
			hc_s1 <= c_half;
			hs_s1 <= s_half;
			ox_s2 <= 33'(rx >>> 16);
			oy_s2 <= 33'(ry >>> 16);
			hc_s2 <= hc_s1;
			hs_s2 <= hs_s1;
		end
	end

	assign cx = jx_q + JW'(ox_s2);
	assign cy = jy_q + JW'(oy_s2);

	always_ff @(posedge clk) begin
		if (en && tag_s2.vld) begin
			out_z_q <= height;
			if (tag_s2.idx == 2'd0) begin
				jx_q     <= JW'($signed(tag_s2.bx));
				jy_q     <= JW'($signed(tag_s2.by));
				out_x_q  <= tag_s2.bx;
				out_y_q  <= tag_s2.by;
				out_qz_q <= 16'h0000;
				out_qw_q <= 16'h7FFF;
			end else begin
				jx_q     <= cx + JW'(ox_s2);
				jy_q     <= cy + JW'(oy_s2);
				out_x_q  <= sat32(cx);
				out_y_q  <= sat32(cy);
				out_qz_q <= hs_s2;
				out_qw_q <= hc_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			out_last_q <= 1'b0;
			out_idx_q  <= '0;
		end else if (en) begin
			out_vld_q  <= tag_s2.vld;
			out_last_q <= tag_s2.last;
			out_idx_q  <= tag_s2.idx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tdata  = {out_qw_q, out_qz_q, out_z_q, out_y_q, out_x_q};

endmodule

FILE: hw/rtl/planar_arm_forward_kinematics.sv
// Planar three-link arm forward kinematics: one item in, four poses out.
// Throughput: one pose per cycle while a job is queued and the output is not
// stalled, set by the back end issuing the base and three link slots in turn
// through two CORDIC pipelines.
// Reset (arst_n low, async): queue and pipeline empty, lengths 1.0, height 0.
// Depends on pafk_pkg, pafk_front, pafk_fifo, pafk_back, pafk_cordic.
module planar_arm_forward_kinematics import pafk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // base_x, base_y, joint_angle_one/two/three
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // pose_x, pose_y, pose_z, quat_z, quat_w
	output logic         m_axis_tlast,  // last_pose
	output logic [1:0]   m_axis_tuser,  // body_index
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] len_one_q, len_two_q, len_three_q, height_q;
	logic        push, q_full, pop, q_nonempty;
	job_t        job_in, job_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_one_q   <= 32'h00010000;
			len_two_q   <= 32'h00010000;
			len_three_q <= 32'h00010000;
			height_q    <= 32'h0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEN_ONE:   len_one_q   <= cfg_data;
				REG_LEN_TWO:   len_two_q   <= cfg_data;
				REG_LEN_THREE: len_three_q <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	pafk_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.push          (push),
		.job           (job_in)
	);

	pafk_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (job_in),
		.full     (q_full),
		.pop      (pop),
		.dout     (job_out),
		.nonempty (q_nonempty)
	);

	pafk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job_out),
		.job_vld       (q_nonempty),
		.job_pop       (pop),
		.len_one       (len_one_q),
		.len_two       (len_two_q),
		.len_three     (len_three_q),
		.height        (height_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
